### rtl/camera_ray_direction_assert.svh
// Assertion macros shared by the camera ray direction block.
`ifndef CAMERA_RAY_DIRECTION_ASSERT_SVH
`define CAMERA_RAY_DIRECTION_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define CRD_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("camera_ray_direction: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define CRD_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("camera_ray_direction: next-cycle check failed");

`endif

### rtl/crd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the camera ray direction block.
package crd_pkg;

    localparam int COORD_BITS_DEF = 12;

    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int STEP_W     = 24;
    localparam int SCALE_W    = 24;
    localparam int ENT_W      = 16;
    localparam int AXIS_W     = 48;
    localparam int DIR_W      = 16;
    localparam int ROUND_SH   = 24;
    localparam int NM_W       = 24;
    localparam int SQ_W       = 48;
    localparam int LEN_W      = 50;
    localparam int ROOT_W     = 25;
    localparam int SQRT_STEPS = 25;
    localparam int FRAC_W     = 14;
    localparam int QUO_W      = 15;
    localparam int NUM_W      = 39;
    localparam int REM_W      = 40;

    localparam logic [QUO_W-1:0] DIR_ONE = 15'd16384;

    localparam logic [STEP_W-1:0]  RST_STEP_X = 24'd16384;
    localparam logic [STEP_W-1:0]  RST_STEP_Y = 24'd21845;
    localparam logic [SCALE_W-1:0] RST_HSCALE = 24'd87381;
    localparam logic [SCALE_W-1:0] RST_VSCALE = 24'd65536;
    localparam logic [ENT_W-1:0]   RST_FWD_Z  = 16'd16384;
    localparam logic [AXIS_W-1:0]  RST_RIGHT  = 48'd16384;
    localparam logic [AXIS_W-1:0]  RST_UP     = 48'd1073741824;
    localparam logic [AXIS_W-1:0]  RST_FWD    = 48'd70368744177664;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_X,
        REG_STEP_Y,
        REG_HSCALE,
        REG_VSCALE,
        REG_FWD_Z,
        REG_RIGHT,
        REG_UP,
        REG_FWD
    } cfg_reg_t;

    typedef struct packed {
        logic [STEP_W-1:0]  step_x;
        logic [STEP_W-1:0]  step_y;
        logic [SCALE_W-1:0] hscale;
        logic [SCALE_W-1:0] vscale;
        logic [ENT_W-1:0]   fwd_z;
        logic [AXIS_W-1:0]  right;
        logic [AXIS_W-1:0]  up;
        logic [AXIS_W-1:0]  fwd;
    } cam_cfg_t;

    typedef struct packed {
        logic valid;
        logic degen;
    } pipe_ctrl_t;

    typedef struct packed {
        logic [2:0][NM_W-1:0] nm;
        logic [2:0]           neg;
    } comp_t;

    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [LEN_W-1:0] root;
    } sqrt_state_t;

    // One step of the bitwise integer square root.
    function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input logic [LEN_W-1:0] b);
        sqrt_state_t      r;
        logic [LEN_W-1:0] trial;
        trial = s.root + b;
        if (s.rem >= trial)
        begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + b;
        end
        else
        begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

    // Picks one signed Q2.14 entry out of a packed axis register.
    function automatic logic signed [ENT_W-1:0] axis_entry(input logic [AXIS_W-1:0] a,
                                                           input logic [1:0] k);
        return $signed(a[ENT_W*k +: ENT_W]);
    endfunction

endpackage

### rtl/camera_ray_direction.sv
`timescale 1ns / 1ps
// Top level of the pinhole camera ray direction generator.
//
//   Channel   Direction  Handshake             Payload
//   config    in         cfg_write             cfg_index, cfg_data
//   pixel     in         in_valid / in_stall   column, row
//   ray       out        out_valid / out_stall dir_x, dir_y, dir_z, degenerate
//
// Every pipeline stage advances together, so while the output is not stalled one pixel
// enters per cycle and one ray leaves per cycle once the pipeline is full. A pixel
// passes 43 registers (7 front stages, 6 normalize stages, 13 square-root stages,
// 16 divider stages and the output register) before its ray is on the outputs.
// While the output register holds a ray that is stalled, the whole pipeline freezes
// and in_stall is raised, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the default camera: right, up and forward
// aligned with x, y and z. There is no clearing pass after reset.
module camera_ray_direction
    import crd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_BITS-1:0]  column,
    input  logic [COORD_BITS-1:0]  row,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [DIR_W-1:0] dir_x,
    output logic signed [DIR_W-1:0] dir_y,
    output logic signed [DIR_W-1:0] dir_z,
    output logic                   degenerate
);

    `include "camera_ray_direction_assert.svh"

    // Width of the world-space direction components before normalization.
    localparam int D_W = COORD_BITS + 45;

    cam_cfg_t cfg_reg, cfg_next;

    // The pipeline moves whenever the output register is empty or being taken.
    logic adv;

    logic                  d_valid;
    logic signed [D_W-1:0] d [3];

    pipe_ctrl_t       nrm_ctrl;
    comp_t            nrm_comp;
    logic [LEN_W-1:0] nrm_len;

    pipe_ctrl_t        sq_ctrl;
    comp_t             sq_comp;
    logic [ROOT_W-1:0] sq_root;

    pipe_ctrl_t       dv_ctrl;
    logic [2:0]       dv_neg;
    logic [QUO_W-1:0] dv_quo [3];

    logic                    out_valid_reg;
    logic                    degen_reg;
    logic [2:0][DIR_W-1:0]   dir_reg;
    logic [2:0][DIR_W-1:0]   dir_next;
    logic [QUO_W-1:0]        qc;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Register writes take the low bits of the data bus that the register needs.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STEP_X: cfg_next.step_x = cfg_data[STEP_W-1:0];
                REG_STEP_Y: cfg_next.step_y = cfg_data[STEP_W-1:0];
                REG_HSCALE: cfg_next.hscale = cfg_data[SCALE_W-1:0];
                REG_VSCALE: cfg_next.vscale = cfg_data[SCALE_W-1:0];
                REG_FWD_Z:  cfg_next.fwd_z  = cfg_data[ENT_W-1:0];
                REG_RIGHT:  cfg_next.right  = cfg_data[AXIS_W-1:0];
                REG_UP:     cfg_next.up     = cfg_data[AXIS_W-1:0];
                REG_FWD:    cfg_next.fwd    = cfg_data[AXIS_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{step_x: RST_STEP_X, step_y: RST_STEP_Y,
                         hscale: RST_HSCALE, vscale: RST_VSCALE,
                         fwd_z: RST_FWD_Z, right: RST_RIGHT,
                         up: RST_UP, fwd: RST_FWD};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    crd_ray_front #(
        .COORD_BITS (COORD_BITS),
        .D_W        (D_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .column   (column),
        .row      (row),
        .cfg      (cfg_reg),
        .d_valid  (d_valid),
        .d        (d)
    );

    crd_normalize #(
        .D_W (D_W)
    ) u_normalize (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .d_valid (d_valid),
        .d       (d),
        .ctrl    (nrm_ctrl),
        .comp    (nrm_comp),
        .len     (nrm_len)
    );

    crd_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctrl  (nrm_ctrl),
        .in_comp  (nrm_comp),
        .len      (nrm_len),
        .out_ctrl (sq_ctrl),
        .out_comp (sq_comp),
        .root     (sq_root)
    );

    crd_divide u_divide (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_ctrl  (sq_ctrl),
        .in_comp  (sq_comp),
        .root     (sq_root),
        .out_ctrl (dv_ctrl),
        .neg      (dv_neg),
        .quo      (dv_quo)
    );

    // Clamp each quotient to one, restore the sign, and force zero for a
    // zero-length direction.
    always_comb
    begin
        qc = '0;
        for (int k = 0; k < 3; k++)
        begin
            qc = (dv_quo[k] > DIR_ONE) ? DIR_ONE : dv_quo[k];
            if (dv_ctrl.degen)
            begin
                dir_next[k] = '0;
            end
            else if (dv_neg[k])
            begin
                dir_next[k] = -DIR_W'(qc);
            end
            else
            begin
                dir_next[k] = DIR_W'(qc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_reg   <= dir_next;
            degen_reg <= dv_ctrl.degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dir_x      = $signed(dir_reg[0]);
    assign dir_y      = $signed(dir_reg[1]);
    assign dir_z      = $signed(dir_reg[2]);
    assign degenerate = degen_reg;

    // A zero-length direction must come out as all zeros.
    `CRD_ASSERT_NOW(a_degen_zero, out_valid && degenerate,
                    dir_x == 16'sd0 && dir_y == 16'sd0 && dir_z == 16'sd0)

    // Every component of a unit direction stays within plus or minus one.
    `CRD_ASSERT_NOW(a_dir_range, out_valid && !degenerate,
                    dir_x <= 16'sd16384 && dir_x >= -16'sd16384
                    && dir_y <= 16'sd16384 && dir_y >= -16'sd16384
                    && dir_z <= 16'sd16384 && dir_z >= -16'sd16384)

    // The largest component of a unit vector is at least one over root three.
    `CRD_ASSERT_NOW(a_dir_major, out_valid && !degenerate,
                    dir_x >= 16'sd9000 || dir_x <= -16'sd9000
                    || dir_y >= 16'sd9000 || dir_y <= -16'sd9000
                    || dir_z >= 16'sd9000 || dir_z <= -16'sd9000)

endmodule

### rtl/crd_ray_front.sv
`timescale 1ns / 1ps
// Pixel to world-space direction: screen mapping, scaling and the view matrix product.
module crd_ray_front
    import crd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int D_W = COORD_BITS + 45
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [COORD_BITS-1:0] column,
    input  logic [COORD_BITS-1:0] row,
    input  cam_cfg_t              cfg,
    output logic                  d_valid,
    output logic signed [D_W-1:0] d [3]
);

    localparam int TMAG_W  = COORD_BITS + 1 + STEP_W;
    localparam int HALF_W  = (TMAG_W + 1) / 2;
    localparam int HI_W    = TMAG_W - HALF_W;
    localparam int LO_P_W  = HALF_W + SCALE_W;
    localparam int HI_P_W  = HI_W + SCALE_W;
    localparam int PR_W    = TMAG_W + SCALE_W + 1;
    localparam int UMAG_W  = PR_W - ROUND_SH;
    localparam int U_W     = UMAG_W + 1;
    localparam int P_W     = U_W + ENT_W;
    localparam int STAGES  = 7;
    localparam logic [TMAG_W-1:0] ONE_T    = TMAG_W'(1) << ROUND_SH;
    localparam logic [PR_W-1:0]   HALF_LSB = PR_W'(1) << (ROUND_SH - 1);

    logic [STAGES-1:0] v_reg;

    logic [TMAG_W-1:0] px_reg, py_reg;
    logic [TMAG_W-1:0] txm_reg, tym_reg;
    logic              txn_reg, tyn_reg;
    logic [LO_P_W-1:0] lox_reg, loy_reg;
    logic [HI_P_W-1:0] hix_reg, hiy_reg;
    logic              txn3_reg, tyn3_reg;
    logic [UMAG_W-1:0] um_reg, vm_reg;
    logic              un_reg, vn_reg;
    logic signed [U_W-1:0] u_reg, v_reg5, w_reg;
    logic signed [P_W-1:0] pr_reg [3];
    logic signed [P_W-1:0] pu_reg [3];
    logic signed [P_W-1:0] pf_reg [3];
    logic signed [D_W-1:0] d_reg [3];

    logic [PR_W-1:0] prx, pry;
    logic signed [P_W-1:0] pr_next [3];
    logic signed [P_W-1:0] pu_next [3];
    logic signed [P_W-1:0] pf_next [3];
    logic signed [D_W-1:0] d_next [3];

    always_comb
    begin
        prx = PR_W'({hix_reg, {HALF_W{1'b0}}}) + PR_W'(lox_reg) + HALF_LSB;
        pry = PR_W'({hiy_reg, {HALF_W{1'b0}}}) + PR_W'(loy_reg) + HALF_LSB;
        for (int k = 0; k < 3; k++)
        begin
            pr_next[k] = P_W'(u_reg) * P_W'(axis_entry(cfg.right, 2'(k)));
            pu_next[k] = P_W'(v_reg5) * P_W'(axis_entry(cfg.up, 2'(k)));
            pf_next[k] = P_W'(w_reg) * P_W'(axis_entry(cfg.fwd, 2'(k)));
            d_next[k]  = D_W'(pr_reg[k]) + D_W'(pu_reg[k]) + D_W'(pf_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= TMAG_W'({column, 1'b1}) * TMAG_W'(cfg.step_x);
            py_reg <= TMAG_W'({row, 1'b1}) * TMAG_W'(cfg.step_y);

            txn_reg <= px_reg < ONE_T;
            txm_reg <= (px_reg < ONE_T) ? ONE_T - px_reg : px_reg - ONE_T;
            tyn_reg <= py_reg > ONE_T;
            tym_reg <= (py_reg > ONE_T) ? py_reg - ONE_T : ONE_T - py_reg;

            lox_reg  <= LO_P_W'(txm_reg[HALF_W-1:0]) * LO_P_W'(cfg.hscale);
            hix_reg  <= HI_P_W'(txm_reg[TMAG_W-1:HALF_W]) * HI_P_W'(cfg.hscale);
            loy_reg  <= LO_P_W'(tym_reg[HALF_W-1:0]) * LO_P_W'(cfg.vscale);
            hiy_reg  <= HI_P_W'(tym_reg[TMAG_W-1:HALF_W]) * HI_P_W'(cfg.vscale);
            txn3_reg <= txn_reg;
            tyn3_reg <= tyn_reg;

            um_reg <= prx[PR_W-1:ROUND_SH];
            vm_reg <= pry[PR_W-1:ROUND_SH];
            un_reg <= txn3_reg;
            vn_reg <= tyn3_reg;

            u_reg  <= un_reg ? -$signed({1'b0, um_reg}) : $signed({1'b0, um_reg});
            v_reg5 <= vn_reg ? -$signed({1'b0, vm_reg}) : $signed({1'b0, vm_reg});
            w_reg  <= U_W'($signed({cfg.fwd_z, 2'b00}));

            pr_reg <= pr_next;
            pu_reg <= pu_next;
            pf_reg <= pf_next;
            d_reg  <= d_next;
        end
    end

    assign d_valid = v_reg[STAGES-1];
    assign d       = d_reg;

endmodule

### rtl/crd_normalize.sv
`timescale 1ns / 1ps
// Magnitudes, leading-one search, common shift to 24 bits and squared length.
module crd_normalize
    import crd_pkg::*;
#(
    parameter int D_W = COORD_BITS_DEF + 45
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  d_valid,
    input  logic signed [D_W-1:0] d [3],
    output pipe_ctrl_t            ctrl,
    output comp_t                 comp,
    output logic [LEN_W-1:0]      len
);

    localparam int MAG_W = D_W;
    localparam int GRPS  = (MAG_W + 7) / 8;
    localparam int GRP_W = $clog2(GRPS);
    localparam int EXT_W = GRPS * 8;
    localparam int BL_W  = $clog2(MAG_W + 1);
    localparam logic [BL_W-1:0] BL_NM = BL_W'(NM_W);

    pipe_ctrl_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    logic [MAG_W-1:0] mag1_reg [3];
    logic [MAG_W-1:0] mag2_reg [3];
    logic [MAG_W-1:0] mag3_reg [3];
    logic [2:0]       neg1_reg, neg2_reg, neg3_reg;
    logic [MAG_W-1:0] or1_reg;
    logic [GRP_W-1:0] grp2_reg;
    logic [7:0]       byte2_reg;
    logic [BL_W-1:0]  bl3_reg;
    comp_t            comp4_reg, comp5_reg, comp6_reg;
    logic [SQ_W-1:0]  sq5_reg [3];
    logic [LEN_W-1:0] len6_reg;

    logic [MAG_W-1:0] mag_next [3];
    logic [EXT_W-1:0] ext;
    logic [GRP_W-1:0] grp_next;
    logic [2:0]       pos_next;
    comp_t            comp4_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_next[k] = d[k][D_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
        end

        ext      = EXT_W'(or1_reg);
        grp_next = '0;
        for (int g = 0; g < GRPS; g++)
        begin
            if (ext[8*g +: 8] != 8'd0)
            begin
                grp_next = GRP_W'(g);
            end
        end

        pos_next = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (byte2_reg[b])
            begin
                pos_next = 3'(b);
            end
        end

        comp4_next.neg = neg3_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (bl3_reg > BL_NM)
            begin
                comp4_next.nm[k] = NM_W'(mag3_reg[k] >> (bl3_reg - BL_NM));
            end
            else
            begin
                comp4_next.nm[k] = NM_W'(mag3_reg[k] << (BL_NM - bl3_reg));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end
        else if (adv)
        begin
            c1_reg <= '{valid: d_valid, degen: 1'b0};
            c2_reg <= '{valid: c1_reg.valid, degen: (or1_reg == '0)};
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
            c6_reg <= c5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag1_reg <= mag_next;
            or1_reg  <= mag_next[0] | mag_next[1] | mag_next[2];
            neg1_reg <= {d[2][D_W-1], d[1][D_W-1], d[0][D_W-1]};

            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            grp2_reg  <= grp_next;
            byte2_reg <= ext[8*grp_next +: 8];

            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            bl3_reg  <= BL_W'({grp2_reg, pos_next}) + BL_W'(1);

            comp4_reg <= comp4_next;

            comp5_reg <= comp4_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq5_reg[k] <= SQ_W'(comp4_reg.nm[k]) * SQ_W'(comp4_reg.nm[k]);
            end

            comp6_reg <= comp5_reg;
            len6_reg  <= LEN_W'(sq5_reg[0]) + LEN_W'(sq5_reg[1]) + LEN_W'(sq5_reg[2]);
        end
    end

    assign ctrl = c6_reg;
    assign comp = comp6_reg;
    assign len  = len6_reg;

endmodule

### rtl/crd_isqrt.sv
`timescale 1ns / 1ps
// Pipelined bitwise integer square root, two result bits per stage, one in the last stage.
module crd_isqrt
    import crd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pipe_ctrl_t        in_ctrl,
    input  comp_t             in_comp,
    input  logic [LEN_W-1:0]  len,
    output pipe_ctrl_t        out_ctrl,
    output comp_t             out_comp,
    output logic [ROOT_W-1:0] root
);

    localparam int SQ_STAGES = (SQRT_STEPS + 1) / 2;

    sqrt_state_t stage_in [SQ_STAGES];
    sqrt_state_t st_reg   [SQ_STAGES];
    comp_t       comp_in  [SQ_STAGES];
    comp_t       comp_reg [SQ_STAGES];
    pipe_ctrl_t  ctrl_in  [SQ_STAGES];
    pipe_ctrl_t  ctrl_reg [SQ_STAGES];

    assign stage_in[0] = '{rem: len, root: '0};
    assign comp_in[0]  = in_comp;
    assign ctrl_in[0]  = in_ctrl;

    for (genvar s = 0; s < SQ_STAGES; s++)
    begin : g_stage
        localparam int STEP_A = 2 * s;
        localparam int STEP_B = 2 * s + 1;
        localparam int SH_B   = (STEP_B < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - STEP_B) : 0;
        localparam logic [LEN_W-1:0] BIT_A = LEN_W'(1) << (2 * (SQRT_STEPS - 1 - STEP_A));
        localparam logic [LEN_W-1:0] BIT_B = LEN_W'(1) << SH_B;

        sqrt_state_t mid;
        sqrt_state_t nxt;

        if (s > 0)
        begin : g_link
            assign stage_in[s] = st_reg[s-1];
            assign comp_in[s]  = comp_reg[s-1];
            assign ctrl_in[s]  = ctrl_reg[s-1];
        end

        always_comb
        begin
            mid = sqrt_step(stage_in[s], BIT_A);
            if (STEP_B < SQRT_STEPS)
            begin
                nxt = sqrt_step(mid, BIT_B);
            end
            else
            begin
                nxt = mid;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctrl_reg[s] <= ctrl_in[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_reg[s]   <= nxt;
                comp_reg[s] <= comp_in[s];
            end
        end
    end

    assign out_ctrl = ctrl_reg[SQ_STAGES-1];
    assign out_comp = comp_reg[SQ_STAGES-1];
    assign root     = st_reg[SQ_STAGES-1].root[ROOT_W-1:0];

endmodule

### rtl/crd_divide.sv
`timescale 1ns / 1ps
// Three-lane pipelined restoring divider, one quotient bit per stage after the first, with rounding.
module crd_divide
    import crd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  pipe_ctrl_t        in_ctrl,
    input  comp_t             in_comp,
    input  logic [ROOT_W-1:0] root,
    output pipe_ctrl_t        out_ctrl,
    output logic [2:0]        neg,
    output logic [QUO_W-1:0]  quo [3]
);

    localparam int DV_STAGES = QUO_W + 1;

    logic [2:0][REM_W-1:0] rem_reg  [DV_STAGES];
    logic [2:0][QUO_W-1:0] q_reg    [DV_STAGES];
    logic [ROOT_W-1:0]     den_reg  [DV_STAGES];
    logic [2:0]            neg_reg  [DV_STAGES];
    pipe_ctrl_t            ctrl_reg [DV_STAGES];

    logic [2:0][REM_W-1:0] rem0_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rem0_next[k] = REM_W'(NUM_W'({in_comp.nm[k], {FRAC_W{1'b0}}})
                                  + NUM_W'(root >> 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg[0] <= '0;
        end
        else if (adv)
        begin
            ctrl_reg[0] <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= rem0_next;
            q_reg[0]   <= '0;
            den_reg[0] <= root;
            neg_reg[0] <= in_comp.neg;
        end
    end

    for (genvar s = 1; s < DV_STAGES; s++)
    begin : g_stage
        localparam int QB = QUO_W - s;

        logic [2:0][REM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;
        logic [REM_W-1:0]      sub;

        always_comb
        begin
            sub = REM_W'(den_reg[s-1]) << QB;
            for (int k = 0; k < 3; k++)
            begin
                rem_next[k] = rem_reg[s-1][k];
                q_next[k]   = q_reg[s-1][k];
                if (rem_reg[s-1][k] >= sub)
                begin
                    rem_next[k]   = rem_reg[s-1][k] - sub;
                    q_next[k][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctrl_reg[s] <= '0;
            end
            else if (adv)
            begin
                ctrl_reg[s] <= ctrl_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
                den_reg[s] <= den_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    assign out_ctrl = ctrl_reg[DV_STAGES-1];
    assign neg      = neg_reg[DV_STAGES-1];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            quo[k] = q_reg[DV_STAGES-1][k];
        end
    end

endmodule

### tb/sv/camera_ray_direction_checker.sv
`timescale 1ns / 1ps
// Checker for the camera ray direction block: tracks the camera registers, predicts rays.
module camera_ray_direction_checker
    import crd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [11:0]             column,
    input  logic [11:0]             row,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic signed [DIR_W-1:0] dir_x,
    input  logic signed [DIR_W-1:0] dir_y,
    input  logic signed [DIR_W-1:0] dir_z,
    input  logic                    degenerate,
    output int                      mismatches,
    output int                      pending,
    output int                      rays_checked,
    output int                      degenerate_rays
);

    typedef struct {
        logic signed [DIR_W-1:0] x;
        logic signed [DIR_W-1:0] y;
        logic signed [DIR_W-1:0] z;
        logic                    degen;
    } ray_t;

    cam_cfg_t cam;
    ray_t     expected_rays[$];

    // Divide by 2^24 with rounding half away from zero.
    function automatic longint round_q24(input longint x);
        if (x < 0)
            return -((-x + (64'sd1 <<< 23)) >>> 24);
        return (x + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic ray_t ray_predict(input logic [11:0] c, input logic [11:0] r);
        longint          tx, ty, u, v, w, d;
        longint unsigned mag[3];
        longint unsigned m, len2, root, rem, bitv, q;
        logic            neg[3];
        int              bl;
        ray_t            res;
        tx = (2 * longint'(c) + 1) * longint'(cam.step_x) - (64'sd1 <<< 24);
        ty = (64'sd1 <<< 24) - (2 * longint'(r) + 1) * longint'(cam.step_y);
        u  = round_q24(tx * longint'(cam.hscale));
        v  = round_q24(ty * longint'(cam.vscale));
        w  = longint'($signed(cam.fwd_z)) * 4;
        m  = 0;
        for (int k = 0; k < 3; k++)
        begin
            d = u * longint'($signed(cam.right[16*k +: 16]))
              + v * longint'($signed(cam.up[16*k +: 16]))
              + w * longint'($signed(cam.fwd[16*k +: 16]));
            neg[k] = d < 0;
            mag[k] = neg[k] ? -d : d;
            if (mag[k] > m)
                m = mag[k];
        end
        if (m == 0)
        begin
            res.x = '0;
            res.y = '0;
            res.z = '0;
            res.degen = 1'b1;
            return res;
        end
        // Bring the largest component into [2^23, 2^24) before the square root.
        bl = 0;
        while ((m >> bl) != 0)
            bl++;
        len2 = 0;
        for (int k = 0; k < 3; k++)
        begin
            mag[k] = (bl > 24) ? (mag[k] >> (bl - 24)) : (mag[k] << (24 - bl));
            len2 += mag[k] * mag[k];
        end
        rem  = len2;
        root = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        for (int k = 0; k < 3; k++)
        begin
            q = ((mag[k] << 14) + (root >> 1)) / root;
            if (q > 16384)
                q = 16384;
            mag[k] = neg[k] ? -q : q;
        end
        res.x = mag[0][15:0];
        res.y = mag[1][15:0];
        res.z = mag[2][15:0];
        res.degen = 1'b0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ray_t exp_ray;
        if (!rst_n)
        begin
            cam.step_x <= RST_STEP_X;
            cam.step_y <= RST_STEP_Y;
            cam.hscale <= RST_HSCALE;
            cam.vscale <= RST_VSCALE;
            cam.fwd_z  <= RST_FWD_Z;
            cam.right  <= RST_RIGHT;
            cam.up     <= RST_UP;
            cam.fwd    <= RST_FWD;
            mismatches      <= 0;
            pending         <= 0;
            rays_checked    <= 0;
            degenerate_rays <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_rays.push_back(ray_predict(column, row));
            if (out_valid && !out_stall)
            begin
                rays_checked <= rays_checked + 1;
                if (expected_rays.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("ERROR: ray with no pixel pending: %0d %0d %0d deg=%0b",
                                 dir_x, dir_y, dir_z, degenerate);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_ray = expected_rays.pop_front();
                    if (exp_ray.degen)
                        degenerate_rays <= degenerate_rays + 1;
                    if (dir_x !== exp_ray.x || dir_y !== exp_ray.y || dir_z !== exp_ray.z
                        || degenerate !== exp_ray.degen)
                    begin
                        if (mismatches < 10)
                            $display("ERROR: ray exp %0d %0d %0d deg=%0b got %0d %0d %0d deg=%0b",
                                     exp_ray.x, exp_ray.y, exp_ray.z, exp_ray.degen,
                                     dir_x, dir_y, dir_z, degenerate);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_rays.size();
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_STEP_X: cam.step_x <= cfg_data[STEP_W-1:0];
                    REG_STEP_Y: cam.step_y <= cfg_data[STEP_W-1:0];
                    REG_HSCALE: cam.hscale <= cfg_data[SCALE_W-1:0];
                    REG_VSCALE: cam.vscale <= cfg_data[SCALE_W-1:0];
                    REG_FWD_Z:  cam.fwd_z  <= cfg_data[ENT_W-1:0];
                    REG_RIGHT:  cam.right  <= cfg_data[AXIS_W-1:0];
                    REG_UP:     cam.up     <= cfg_data[AXIS_W-1:0];
                    REG_FWD:    cam.fwd    <= cfg_data[AXIS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/tb_camera_ray_direction.sv
`timescale 1ns / 1ps
// Testbench top for the camera ray direction block: stimulus, idling and the verdict.
module tb_camera_ray_direction;
    import crd_pkg::*;

    // Drain wait before touching registers, longer than the pipeline is deep.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [11:0]             column = '0;
    logic [11:0]             row = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [DIR_W-1:0] dir_x, dir_y, dir_z;
    logic                    degenerate;

    int mismatches, pending, rays_checked, degenerate_rays;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_cycles = 0;
    int cycles = 0;
    int pixels_sent = 0;

    always #5 clk = ~clk;

    camera_ray_direction i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .column(column), .row(row),
        .out_valid(out_valid), .out_stall(out_stall),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .degenerate(degenerate)
    );

    camera_ray_direction_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .column(column), .row(row),
        .out_valid(out_valid), .out_stall(out_stall),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .degenerate(degenerate),
        .mismatches(mismatches), .pending(pending),
        .rays_checked(rays_checked), .degenerate_rays(degenerate_rays)
    );

    // The ray receiver. A requested hold-off is counted down here and keeps the output
    // stalled for the whole stretch, so the pipeline fills and the pixel side stalls too.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Watchdog: a hung handshake must not hang the run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Writes one camera register on the plain write port.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offers one pixel, with random idle cycles first, and waits for its transfer.
    // Valid is left high afterwards so back-to-back pixels keep a full-rate stream.
    task automatic send_pixel(input logic [11:0] c, input logic [11:0] r);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        column   <= c;
        row      <= r;
        do
            @(posedge clk);
        while (in_stall);
        pixels_sent++;
    endtask

    // Lowers valid and lets every ray come out before the camera is changed.
    task automatic drain_pipeline();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [AXIS_W-1:0] random_axis();
        return {16'($urandom_range(65535)), 16'($urandom_range(65535)),
                16'($urandom_range(65535))};
    endfunction

    // Loads a full camera. Style zero picks ordinary random values; styles one and two push
    // the steps, scales and axis entries to their extremes, and style three is a small camera.
    task automatic load_camera(input int style);
        logic [STEP_W-1:0]  sx, sy;
        logic [SCALE_W-1:0] hs, vs;
        logic [ENT_W-1:0]   fz;
        logic [AXIS_W-1:0]  ra, ua, fa;
        sx = STEP_W'($urandom_range(8388608));
        sy = STEP_W'($urandom_range(8388608));
        hs = SCALE_W'($urandom_range(24'hFFFFFF));
        vs = SCALE_W'($urandom_range(24'hFFFFFF));
        fz = ENT_W'($urandom_range(65535));
        ra = random_axis();
        ua = random_axis();
        fa = random_axis();
        case (style)
            1:
            begin
                // Widest steps and scales with the most negative entries everywhere.
                sx = 24'd8388608;
                sy = 24'd8388608;
                hs = 24'hFFFFFF;
                vs = 24'hFFFFFF;
                fz = 16'h8000;
                ra = {3{16'h8000}};
                ua = {3{16'h8000}};
                fa = {3{16'h8000}};
            end
            2:
            begin
                // Zero steps collapse the image to its corner; largest positive right and forward z entries.
                sx = '0;
                sy = '0;
                hs = 24'd1;
                vs = 24'hFFFFFF;
                fz = 16'h7FFF;
                ra = {3{16'h7FFF}};
                ua = {16'h7FFF, 16'h8000, 16'hFFFF};
                fa = {3{16'hFFFF}};
            end
            3:
            begin
                // Small realistic camera, for a 64 by 48 image.
                sx = 24'd262144;
                sy = 24'd349525;
                hs = 24'd87381;
                vs = 24'd65536;
            end
            default: ;
        endcase
        write_reg(REG_STEP_X, CFG_DATA_W'(sx));
        write_reg(REG_STEP_Y, CFG_DATA_W'(sy));
        write_reg(REG_HSCALE, CFG_DATA_W'(hs));
        write_reg(REG_VSCALE, CFG_DATA_W'(vs));
        write_reg(REG_FWD_Z, CFG_DATA_W'(fz));
        write_reg(REG_RIGHT, ra);
        write_reg(REG_UP, ua);
        write_reg(REG_FWD, fa);
    endtask

    initial
    begin
        logic [11:0] c, r;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed pixels on the reset camera: corners, center and the field extremes.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd511, 12'd383);
        send_pixel(12'd512, 12'd384);
        send_pixel(12'd1023, 12'd767);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain_pipeline();

        // A camera with zero forward and zero scales has zero length for every pixel.
        write_reg(REG_HSCALE, '0);
        write_reg(REG_VSCALE, '0);
        write_reg(REG_FWD_Z, '0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd17);
        drain_pipeline();
        // With all axes zero the direction vanishes even though u, v and w do not.
        write_reg(REG_HSCALE, CFG_DATA_W'(24'hFFFFFF));
        write_reg(REG_VSCALE, CFG_DATA_W'(24'd65536));
        write_reg(REG_FWD_Z, CFG_DATA_W'(16'h7FFF));
        write_reg(REG_RIGHT, '0);
        write_reg(REG_UP, '0);
        write_reg(REG_FWD, '0);
        drain_pipeline();
        send_pixel(12'd100, 12'd200);
        send_pixel(12'd4095, 12'd4095);
        drain_pipeline();

        // Extreme cameras, directed corners on each.
        for (int s = 1; s <= 2; s++)
        begin
            load_camera(s);
            send_pixel(12'd0, 12'd0);
            send_pixel(12'd4095, 12'd4095);
            send_pixel(12'd0, 12'd4095);
            send_pixel(12'd4095, 12'd0);
            drain_pipeline();
        end

        // Random pixels, one camera per phase, cycling through the idling modes.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            load_camera(phase % 4);
            // In the first full-rate phase the receiver holds off for a long stretch.
            if (phase == 0)
                hold_cycles = 200;
            for (int i = 0; i < 66; i++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    c = 12'($urandom_range(4095));
                    r = 12'($urandom_range(4095));
                end
                else
                begin
                    // Mostly pixels that lie inside a modest frame.
                    c = 12'($urandom_range(63));
                    r = 12'($urandom_range(47));
                end
                send_pixel(c, r);
            end
            drain_pipeline();
        end

        $display("Sent %0d pixels over reset, degenerate, extreme and random cameras;",
                 pixels_sent);
        $display("checked %0d rays, %0d of them degenerate, under four idling modes.",
                 rays_checked, degenerate_rays);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/crd_pkg.sv
rtl/crd_ray_front.sv
rtl/crd_normalize.sv
rtl/crd_isqrt.sv
rtl/crd_divide.sv
rtl/camera_ray_direction.sv
tb/sv/camera_ray_direction_checker.sv
tb/sv/tb_camera_ray_direction.sv
